[rtl/core/vort2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vorticity unit package
// Shared word types, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package vort2d_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int VORT_BITS       = SAMPLE_BITS + 1;
  localparam int SUM_BITS        = SAMPLE_BITS + 2;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 16;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int ROW_BITS        = CFG_HEIGHT_BITS + 1;

  localparam logic [CFG_WIDTH_BITS-1:0]  RESET_GRID_WIDTH  = 11'd64;
  localparam logic [CFG_HEIGHT_BITS-1:0] RESET_GRID_HEIGHT = 16'd64;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_index_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] vel_x;
    logic signed [SAMPLE_BITS-1:0] vel_y;
  } vel_point_t;

  typedef struct packed {
    logic signed [VORT_BITS-1:0] vorticity;
    logic                        last_in_frame;
  } vort_result_t;

  // Per-word decisions made by the raster scanner at the accepting edge.
  typedef struct packed {
    logic emit;
    logic last;
    logic right_ok;
  } scan_flags_t;

endpackage

[rtl/core/vorticity_2d_central_difference_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 2D vorticity unit
// Central-difference curl over a raster stream of velocity points.
// ----------------------------------------------------------------------------
// The input channel takes one grid point a word, ghost border included, in
// raster order; a word is taken when in_valid_i is high and in_stall_o low.
// A frame streams at one point a clock while in_stall_o is low; the rate
// is set by the single read-modify-write pass through the line buffer RAMs
// per word. The word directly below an interior cell completes that cell:
// its result is registered behind the line buffer reads and then pushed
// into the output queue. Ghost words only refresh the line buffers.
// Results wait in a four-entry queue while out_stall_i is high; in_stall_o
// rises only once that queue cannot take the words still in flight.
// The configuration channel is always ready; write grid_width and
// grid_height only between frames while no result is outstanding.
// Reset returns both sizes to 64 and the scan to the first ghost point. The
// line buffers are not cleared: every entry a result uses is written first.
// ----------------------------------------------------------------------------
module vorticity_2d_central_difference_unit import vort2d_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  vel_point_t                in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output vort_result_t              out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int BufDepth = MAX_WIDTH + 2;
  localparam int AddrBits = $clog2(BufDepth);

  logic                in_accept;
  logic [AddrBits-1:0] col;
  logic [AddrBits-1:0] right_col;
  scan_flags_t         flags;
  scan_flags_t         b_flags_q;
  logic                b_valid_q;
  sample_t             b_vx_q;
  sample_t             vy_left_q;
  sample_t             top_vx;
  sample_t             old_vy;
  sample_t             right_vy;
  sample_t             right_term;
  sum_t                curl_sum;
  logic                push;
  vort_result_t        push_data;
  logic                queue_full;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = queue_full;

  vort2d_scan_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (in_accept),
    .col_o       (col),
    .right_col_o (right_col),
    .flags_o     (flags)
  );

  vort2d_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_accept),
    .col_i       (col),
    .right_col_i (right_col),
    .vel_i       (in_data_i),
    .top_vx_o    (top_vx),
    .old_vy_o    (old_vy),
    .right_vy_o  (right_vy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_flags_q <= '0;
    end else begin
      b_valid_q <= in_accept;
      if (in_accept) begin
        b_flags_q <= flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_vx_q <= in_data_i.vel_x;
    end
  end

  // The y velocity of the column to the left in the row above trails the
  // RAM read by one word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vy_left_q <= '0;
    end else if (b_valid_q) begin
      vy_left_q <= old_vy;
    end
  end

  assign right_term = b_flags_q.right_ok ? right_vy : '0;
  assign curl_sum   = sum_t'(right_term) - sum_t'(vy_left_q) - sum_t'(b_vx_q) +
                      sum_t'(top_vx);

  assign push                    = b_valid_q && b_flags_q.emit;
  assign push_data.vorticity     = curl_sum[SUM_BITS-1:1];
  assign push_data.last_in_frame = b_flags_q.last;

  vort2d_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pending_i   (push),
    .full_o      (queue_full),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o),
    .stall_i     (out_stall_i)
  );

endmodule

[rtl/core/vort2d_scan_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster scanner
// Holds the grid size registers and the column and row counters, and decides
// for each word whether it completes an interior cell.
// ----------------------------------------------------------------------------
module vort2d_scan_ctrl import vort2d_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int BufDepth = MAX_WIDTH + 2,
  localparam int AddrBits = $clog2(BufDepth),
  localparam int ColBits  = $clog2(BufDepth + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                      advance_i,
  output logic [AddrBits-1:0]       col_o,
  output logic [AddrBits-1:0]       right_col_o,
  output scan_flags_t               flags_o
);

  logic [CFG_WIDTH_BITS-1:0]  grid_width_q;
  logic [CFG_HEIGHT_BITS-1:0] grid_height_q;
  logic [ColBits-1:0]         col_q, col_d;
  logic [ROW_BITS-1:0]        row_q, row_d;
  logic [ColBits-1:0]         width_eff;
  logic [ColBits-1:0]         width_p1;
  logic [ROW_BITS-1:0]        height_p1;
  logic [ColBits:0]           col_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= RESET_GRID_WIDTH;
      grid_height_q <= RESET_GRID_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[CFG_WIDTH_BITS-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[CFG_HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are pulled back into the supported range.
  always_comb begin
    if (grid_width_q == '0) begin
      width_eff = ColBits'(1);
    end else if (32'(grid_width_q) > MAX_WIDTH) begin
      width_eff = ColBits'(MAX_WIDTH);
    end else begin
      width_eff = ColBits'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      height_p1 = ROW_BITS'(2);
    end else begin
      height_p1 = ROW_BITS'(grid_height_q) + ROW_BITS'(1);
    end
  end

  assign width_p1 = width_eff + ColBits'(1);
  assign col_next = {1'b0, col_q} + (ColBits + 1)'(1);

  always_comb begin
    flags_o.emit     = (row_q >= ROW_BITS'(2)) && (row_q <= height_p1) &&
                       (col_q != '0) && (col_q <= width_eff);
    flags_o.last     = (row_q == height_p1) && (col_q == width_eff);
    flags_o.right_ok = (col_next < (ColBits + 1)'(BufDepth));
  end

  assign col_o       = col_q[AddrBits-1:0];
  assign right_col_o = flags_o.right_ok ? col_next[AddrBits-1:0] : '0;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_q >= width_p1) begin
      col_d = '0;
      row_d = (row_q >= height_p1) ? '0 : row_q + ROW_BITS'(1);
    end else begin
      col_d = col_next[ColBits-1:0];
      if (row_q > height_p1) begin
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[rtl/core/vort2d_line_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line buffers
// Two rows of x velocity and one row of y velocity in synchronous RAMs. The
// older x row is refreshed in the cycle after the read that supplies its data.
// ----------------------------------------------------------------------------
module vort2d_line_buf import vort2d_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int BufDepth = MAX_WIDTH + 2,
  localparam int AddrBits = $clog2(BufDepth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] col_i,
  input  logic [AddrBits-1:0] right_col_i,
  input  vel_point_t          vel_i,
  output sample_t             top_vx_o,
  output sample_t             old_vy_o,
  output sample_t             right_vy_o
);

  sample_t vx1_mem [BufDepth];
  sample_t vx2_mem [BufDepth];
  sample_t vy_mem  [BufDepth];

  sample_t             vx1_rd_q;
  sample_t             vx2_rd_q;
  sample_t             vy_rd_q;
  sample_t             vy_right_q;
  logic                pend_q;
  logic [AddrBits-1:0] pend_col_q;

  // Read-first: the read returns the row above before this word replaces it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      vx1_rd_q       <= vx1_mem[col_i];
      vx1_mem[col_i] <= vel_i.vel_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      vy_rd_q       <= vy_mem[col_i];
      vy_right_q    <= vy_mem[right_col_i];
      vy_mem[col_i] <= vel_i.vel_y;
    end
  end

  // Consecutive words never share a column, so the delayed write cannot
  // collide with the read of the following word.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      vx2_rd_q <= vx2_mem[col_i];
    end
    if (pend_q) begin
      vx2_mem[pend_col_q] <= vx1_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= rd_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      pend_col_q <= col_i;
    end
  end

  assign top_vx_o   = vx2_rd_q;
  assign old_vy_o   = vy_rd_q;
  assign right_vy_o = vy_right_q;

endmodule

[rtl/core/vort2d_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output queue
// Four-entry result queue that decouples the datapath from the receiver.
// ----------------------------------------------------------------------------
module vort2d_out_fifo import vort2d_pkg::*; #(
  localparam int Depth   = 4,
  localparam int PtrBits = $clog2(Depth),
  localparam int CntBits = $clog2(Depth + 2)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  vort_result_t push_data_i,
  input  logic         pending_i,
  output logic         full_o,
  output logic         valid_o,
  output vort_result_t data_o,
  input  logic         stall_i
);

  vort_result_t        entries_q [Depth];
  logic [PtrBits-1:0]  wr_ptr_q;
  logic [PtrBits-1:0]  rd_ptr_q;
  logic [CntBits-1:0]  count_q;
  logic                pop;

  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign pop     = valid_o && !stall_i;

  // Room is kept for the word in flight and for one more accepted now.
  assign full_o = (count_q + CntBits'(pending_i)) >= CntBits'(Depth);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      end
      count_q <= count_q + CntBits'(push_i) - CntBits'(pop);
    end
  end

endmodule

[sim/tb_vorticity_2d_central_difference_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 2D vorticity unit
// Streams velocity frames of many sizes through the unit, ghost border
// included, and predicts the curl of every interior cell in step with the
// accepted words. Results are checked field by field, in order, under random
// idling on both channels, a long output hold-off and mid-frame resizing.
// ----------------------------------------------------------------------------
module tb_vorticity_2d_central_difference_unit;
  import vort2d_pkg::*;

  localparam int MAX_WIDTH        = 1024;
  localparam int BUF_DEPTH        = MAX_WIDTH + 2;
  localparam int RESET_CYCLES     = 10;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int RANDOM_ITEMS     = 350;
  localparam int QUIET_ITEMS      = 150;
  localparam int PRINT_LIMIT      = 40;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  vel_point_t                in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  vort_result_t              out_data_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i  = '0;

  // Predictor state: a copy of the sizes and of the line buffers.
  logic [CFG_WIDTH_BITS-1:0]  grid_width_reg  = RESET_GRID_WIDTH;
  logic [CFG_HEIGHT_BITS-1:0] grid_height_reg = RESET_GRID_HEIGHT;
  sample_t                    vx_one_back [BUF_DEPTH];
  sample_t                    vx_two_back [BUF_DEPTH];
  sample_t                    vy_one_back [BUF_DEPTH];
  sample_t                    vy_left     = '0;
  int unsigned                scan_col    = 0;
  int unsigned                scan_row    = 0;

  vort_result_t curl_expected [$];
  vort_result_t expected_head;

  bit          idle_on           = 1'b1;
  bit          long_hold_pending = 1'b0;
  int unsigned items_sent        = 0;
  int unsigned results_checked   = 0;
  int unsigned stall_cycles      = 0;
  int unsigned grid_settings     = 0;
  int unsigned error_count       = 0;
  int unsigned quiet_cycles      = 0;

  vorticity_2d_central_difference_unit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned active_width();
    int unsigned w;
    w = grid_width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // Advances the raster scan by one accepted word and queues the curl of the
  // cell above it when that cell is interior.
  function automatic void advance_curl_scan(input vel_point_t p);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    sample_t      right;
    sample_t      old_vy;
    int           diff;
    vort_result_t res;
    w = active_width();
    h = (grid_height_reg == 0) ? 1 : grid_height_reg;
    c = scan_col;
    r = scan_row;
    right  = (c + 1 < BUF_DEPTH) ? vy_one_back[c + 1] : '0;
    old_vy = vy_one_back[c];
    if (r >= 2 && r <= h + 1 && c >= 1 && c <= w) begin
      diff = int'(right) - int'(vy_left) - int'(p.vel_x) + int'(vx_two_back[c]);
      res.vorticity     = VORT_BITS'(diff >>> 1);
      res.last_in_frame = (r == h + 1 && c == w);
      curl_expected.push_back(res);
    end
    vx_two_back[c] = vx_one_back[c];
    vx_one_back[c] = p.vel_x;
    vy_one_back[c] = p.vel_y;
    vy_left        = old_vy;
    if (c >= w + 1) begin
      scan_col = 0;
      scan_row = (r >= h + 1) ? 0 : r + 1;
    end else begin
      scan_col = c + 1;
      if (r > h + 1) scan_row = 0;
    end
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic vel_point_t random_point();
    vel_point_t p;
    p.vel_x = random_sample();
    p.vel_y = random_sample();
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Offers one word and returns at the edge that takes it.
  task automatic send_point(input vel_point_t p);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) begin
      stall_cycles++;
      @(posedge clk_i);
    end
    items_sent++;
    advance_curl_scan(p);
  endtask

  task automatic stream_points(input int unsigned count);
    repeat (count) send_point(random_point());
  endtask

  // Sends random words until the scan is back at the first ghost point.
  task automatic stream_frame();
    do send_point(random_point());
    while (scan_col != 0 || scan_row != 0);
  endtask

  // Lets every outstanding result drain, then lets ghost words still in the
  // pipeline settle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (curl_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_grid(input logic [CFG_DATA_BITS-1:0] width_data,
                              input logic [CFG_DATA_BITS-1:0] height_data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_GRID_WIDTH;
    cfg_data_i  <= width_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    grid_width_reg = width_data[CFG_WIDTH_BITS-1:0];
    cfg_index_i <= CFG_GRID_HEIGHT;
    cfg_data_i  <= height_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    grid_height_reg = height_data[CFG_HEIGHT_BITS-1:0];
    cfg_valid_i <= 1'b0;
    grid_settings++;
  endtask

  // Starts at the reset size, then shrinks both sizes part way through a row
  // so that the column counter is past its new end and the row counter at it.
  task automatic test_resize_mid_frame();
    stream_points(3 * (RESET_GRID_WIDTH + 2) + 40);
    program_grid(16'hF805, 16'd2);
    stream_frame();
    stream_frame();
  endtask

  // Single-cell frames whose curl reaches the largest and smallest values.
  task automatic test_extreme_curl();
    vel_point_t p;
    sample_t    hi;
    sample_t    lo;
    program_grid(16'd1, 16'd1);
    for (int pass = 0; pass < 2; pass++) begin
      hi = (pass == 0) ? SAMPLE_MAX : SAMPLE_MIN;
      lo = (pass == 0) ? SAMPLE_MIN : SAMPLE_MAX;
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          p = '0;
          if (y == 1 && x == 2) p.vel_y = hi;
          if (y == 1 && x == 0) p.vel_y = lo;
          if (y == 0 && x == 1) p.vel_x = hi;
          if (y == 2 && x == 1) p.vel_x = lo;
          send_point(p);
        end
      end
    end
  endtask

  // Tallest frame setting, cut short by a mid-frame height change, then the
  // zero sizes that act as one.
  task automatic test_tall_and_zero_sizes();
    program_grid(16'd2, 16'hFFFF);
    stream_points(4 * 12);
    program_grid(16'd2, 16'd4);
    stream_frame();
    program_grid(16'd0, 16'd0);
    stream_frame();
    stream_frame();
  endtask

  // Widest rows: a width above the buffer size is clamped, so the first row
  // must wrap after the last buffer column. The second row is then cut short
  // by a narrow width, and the cells of the third row show where the wrap
  // fell.
  task automatic test_wide_rows();
    program_grid(16'hFFFF, 16'd1);
    stream_points(BUF_DEPTH + 10);
    program_grid(16'd3, 16'd1);
    stream_frame();
  endtask

  // The output is held off for a long stretch while words keep coming, so
  // the result queue fills and the input stalls.
  task automatic test_back_pressure();
    program_grid(16'd6, 16'd4);
    long_hold_pending = 1'b1;
    stream_frame();
  endtask

  task automatic test_random_frames();
    int unsigned goal;
    int unsigned w;
    int unsigned h;
    int unsigned frame_words;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      idle_on = (items_sent + QUIET_ITEMS < goal) && ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      h = $urandom_range(0, 8);
      program_grid({5'($urandom), 11'(w)}, 16'(h));
      if ($urandom_range(0, 5) == 0) begin
        // Broken frame: stop part way, then shrink the width (never grow it,
        // so no unwritten buffer entry is read) and change the height.
        frame_words = (active_width() + 2) * (((h == 0) ? 1 : h) + 2);
        stream_points($urandom_range(1, frame_words - 1));
        program_grid(16'($urandom_range(1, active_width())), 16'($urandom_range(0, 8)));
      end
      stream_frame();
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && rst_ni && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (curl_expected.size() == 0) begin
        report_mismatch("unexpected result word", int'(out_data_o.vorticity), 0);
      end else begin
        expected_head = curl_expected.pop_front();
        results_checked++;
        if (out_data_o.vorticity !== expected_head.vorticity)
          report_mismatch("vorticity", int'(out_data_o.vorticity),
                          int'(expected_head.vorticity));
        if (out_data_o.last_in_frame !== expected_head.last_in_frame)
          report_mismatch("last_in_frame", int'(out_data_o.last_in_frame),
                          int'(expected_head.last_in_frame));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[vorticity_2d_central_difference_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    foreach (vx_one_back[i]) begin
      vx_one_back[i] = '0;
      vx_two_back[i] = '0;
      vy_one_back[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_resize_mid_frame();
    test_extreme_curl();
    test_tall_and_zero_sizes();
    test_wide_rows();
    test_back_pressure();
    test_random_frames();
    settle();
    $display("Streamed %0d grid points over %0d grid settings and checked %0d curl results.",
             items_sent, grid_settings, results_checked);
    $display("Input held back for %0d cycles; %0d mismatches found.",
             stall_cycles, error_count);
    if (error_count == 0) begin
      $display("[vorticity_2d_central_difference_unit] OK");
    end else begin
      $display("[vorticity_2d_central_difference_unit] ERROR");
    end
    $finish;
  end

endmodule
